// ----- rtl/sclru_pkg.sv -----
// Shared types and constants for the sector cache LRU directory.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sclru_pkg;

  localparam int DEF_ENTRIES   = 64;
  localparam int DEF_ADDR_BITS = 48;

  localparam int CAP_W       = 7;
  localparam int CAP_RESET   = 64;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 6;
  localparam int EV_ADDR_W   = 48;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_PAD_W   = OUT_DATA_W - SLOT_W - 1 - EV_ADDR_W;
  localparam int CFG_IDX_W   = 1;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INV   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RSVD  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_READ_MISS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OOB         = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALIDATED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_SECTORS = 1'd1;

  typedef enum logic [1:0] {
    SW_CLEAR  = 2'd0,
    SW_SCAN   = 2'd1,
    SW_UPDATE = 2'd2
  } sclru_sweep_t;

  typedef struct packed {
    logic         accept;
    logic         sweep_start;
    sclru_sweep_t sweep_mode;
    logic         set_early;
    logic         decide;
    logic         load_out;
  } sclru_cmd_t;

  typedef struct packed {
    logic is_inv;
    logic is_oob;
    logic sweep_done;
    logic need_update;
    logic out_free;
  } sclru_stat_t;

endpackage

// ----- rtl/sector_cache_lru_directory.sv -----
// Sector cache LRU directory, top level: joins sclru_ctrl and sclru_datapath.
// One request at a time. Out of bounds needs no sweep, invalidate runs a clearing sweep,
// read miss runs a tag scan, and hit or write runs a tag scan plus a rank update sweep
// (one entry per cycle).
// in_tready rises in the same cycle as out_tvalid, so the next request can be taken then.
// Reset: synchronous; a clearing sweep of all entries then holds in_tready low.
`timescale 1ns / 1ps

module sector_cache_lru_directory
  import sclru_pkg::*;
#(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int ADDR_BITS = DEF_ADDR_BITS
)(
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_addr,
  input  logic [((ADDR_BITS > CAP_W) ? ADDR_BITS : CAP_W)-1:0] cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // sector_addr
  input  logic [((ADDR_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // func
  input  logic [FUNC_W-1:0]                     in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // slot, evicted, evicted_addr
  output logic [OUT_DATA_W-1:0]                 out_tdata,
  // status
  output logic [STATUS_W-1:0]                   out_tuser
);

  localparam int IN_DATA_W = ((ADDR_BITS + 7) / 8) * 8;
  localparam int CFG_W     = (ADDR_BITS > CAP_W) ? ADDR_BITS : CAP_W;

  sclru_cmd_t  cmd;
  sclru_stat_t stat;

  sclru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sclru_datapath #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS),
    .IN_DATA_W (IN_DATA_W),
    .CFG_W     (CFG_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

  a_accept_idle_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> stat.sweep_done)
    else $error("request accepted while a sweep is running");

  a_no_sweep_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_start |-> stat.sweep_done)
    else $error("sweep started over a running sweep");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

  a_result_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("loaded result not presented");

endmodule

// ----- rtl/sclru_ctrl.sv -----
// Controller state machine for the sector cache LRU directory.
// Sequences clear, scan, decide and update sweeps; depends on sclru_pkg.
`timescale 1ns / 1ps

module sclru_ctrl
  import sclru_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  sclru_stat_t stat,
  output sclru_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_INIT     = 9'b000000001,
    S_CLR_INIT = 9'b000000010,
    S_IDLE     = 9'b000000100,
    S_DISPATCH = 9'b000001000,
    S_CLR_INV  = 9'b000010000,
    S_SCAN     = 9'b000100000,
    S_DECIDE   = 9'b001000000,
    S_UPDATE   = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.sweep_mode  = SW_CLEAR;
    cmd.accept      = in_tvalid && in_tready;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep_start = 1'b1;
        cmd.sweep_mode  = SW_CLEAR;
        state_nxt       = S_CLR_INIT;
      end
      S_CLR_INIT: begin
        if (stat.sweep_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.is_inv) begin
          cmd.set_early   = 1'b1;
          cmd.sweep_start = 1'b1;
          cmd.sweep_mode  = SW_CLEAR;
          state_nxt       = S_CLR_INV;
        end else if (stat.is_oob) begin
          cmd.set_early = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_mode  = SW_SCAN;
          state_nxt       = S_SCAN;
        end
      end
      S_CLR_INV: begin
        if (stat.sweep_done) state_nxt = S_RESP;
      end
      S_SCAN: begin
        if (stat.sweep_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.need_update) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_mode  = SW_UPDATE;
          state_nxt       = S_UPDATE;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_UPDATE: begin
        if (stat.sweep_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/sclru_datapath.sv -----
// Datapath for the sector cache LRU directory: config registers, entry
// memory with its sweep engine, scan bookkeeping and result registers.
// Depends on sclru_pkg; driven by sclru_ctrl.
`timescale 1ns / 1ps

module sclru_datapath
  import sclru_pkg::*;
#(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int IN_DATA_W = ((DEF_ADDR_BITS + 7) / 8) * 8,
  parameter int CFG_W     = DEF_ADDR_BITS
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser,
  input  sclru_cmd_t            cmd,
  output sclru_stat_t           stat
);

  localparam int IDXW   = $clog2(ENTRIES);
  localparam int CNTW   = $clog2(ENTRIES + 1);
  localparam int CMPW   = (CNTW > CAP_W) ? CNTW : CAP_W;
  localparam int WORD_W = 1 + IDXW + ADDR_BITS;

  logic [CAP_W-1:0]     cap_r;
  logic [ADDR_BITS-1:0] dev_r;

  logic [FUNC_W-1:0]    func_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic                 oob_r;
  logic [CNTW-1:0]      occ_r;

  logic                 sw_act_r;
  sclru_sweep_t         sw_mode_r;
  logic [IDXW-1:0]      sw_cnt_r;
  logic                 p_vld_r;
  logic [IDXW-1:0]      p_idx_r;

  logic [WORD_W-1:0]    mem [ENTRIES];
  logic [WORD_W-1:0]    rd_q_r;
  logic                 mem_we;
  logic [IDXW-1:0]      mem_wa;
  logic [WORD_W-1:0]    mem_wd;

  logic                 q_valid;
  logic [IDXW-1:0]      q_rank;
  logic [ADDR_BITS-1:0] q_tag;
  logic [IDXW-1:0]      rank_inc;

  logic                 hit_found_r, free_found_r, worst_have_r;
  logic [IDXW-1:0]      hit_idx_r, hit_rank_r, free_idx_r, worst_idx_r, worst_rank_r;
  logic [ADDR_BITS-1:0] worst_tag_r;

  logic [IDXW-1:0]      tgt_r, limit_r;
  logic                 inc_all_r, wr_tag_r;

  logic [STATUS_W-1:0]  res_status_r;
  logic [IDXW-1:0]      res_slot_r;
  logic                 res_ev_r;
  logic [ADDR_BITS-1:0] res_ev_addr_r;

  logic [CMPW-1:0]      cap_ext, eff_cap, occ_ext;
  logic                 is_write, evict_case;
  logic                 in_oob;
  logic [ADDR_BITS-1:0] in_addr;

  logic [SLOT_W+IDXW-1:0]         slot_ext;
  logic [EV_ADDR_W+ADDR_BITS-1:0] ev_ext;

  assign in_addr = in_tdata[ADDR_BITS-1:0];
  assign in_oob  = (in_tuser == FUNC_RSVD) ||
                   ((in_tuser != FUNC_INV) && (in_addr >= dev_r));

  assign q_valid  = rd_q_r[WORD_W-1];
  assign q_rank   = rd_q_r[WORD_W-2 -: IDXW];
  assign q_tag    = rd_q_r[ADDR_BITS-1:0];
  assign rank_inc = q_rank + IDXW'(1);

  always_comb begin
    cap_ext = CMPW'(cap_r);
    eff_cap = cap_ext;
    if (cap_ext == '0) eff_cap = CMPW'(1);
    if (cap_ext > CMPW'(ENTRIES)) eff_cap = CMPW'(ENTRIES);
  end

  assign occ_ext    = CMPW'(occ_r);
  assign is_write   = (func_r == FUNC_WRITE);
  assign evict_case = (occ_ext >= eff_cap) && (occ_r != '0);

  assign stat.is_inv      = (func_r == FUNC_INV);
  assign stat.is_oob      = oob_r;
  assign stat.sweep_done  = !sw_act_r && !p_vld_r;
  assign stat.need_update = hit_found_r || is_write;
  assign stat.out_free    = !out_tvalid || out_tready;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = sw_cnt_r;
    mem_wd = '0;
    case (sw_mode_r)
      SW_CLEAR: begin
        mem_we = sw_act_r;
      end
      SW_UPDATE: begin
        mem_we = p_vld_r;
        mem_wa = p_idx_r;
        mem_wd = rd_q_r;
        if (p_idx_r == tgt_r) begin
          mem_wd = {1'b1, {IDXW{1'b0}}, (wr_tag_r ? addr_r : q_tag)};
        end else if (q_valid && (inc_all_r || (q_rank < limit_r))) begin
          mem_wd = {1'b1, rank_inc, q_tag};
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q_r <= mem[sw_cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_W'(CAP_RESET);
      dev_r    <= '0;
      sw_act_r <= 1'b0;
      p_vld_r  <= 1'b0;
      occ_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_CAPACITY:       cap_r <= cfg_wdata[CAP_W-1:0];
          REG_DEVICE_SECTORS: dev_r <= cfg_wdata[ADDR_BITS-1:0];
          default:            cap_r <= cap_r;
        endcase
      end
      p_vld_r <= sw_act_r && (sw_mode_r != SW_CLEAR);
      if (cmd.sweep_start) begin
        sw_act_r <= 1'b1;
      end else if (sw_act_r && (sw_cnt_r == IDXW'(ENTRIES - 1))) begin
        sw_act_r <= 1'b0;
      end
      if (cmd.set_early && stat.is_inv) begin
        occ_r <= '0;
      end else if (cmd.decide && !hit_found_r && is_write && !evict_case) begin
        occ_r <= occ_r + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r <= sw_cnt_r;
    if (cmd.sweep_start) begin
      sw_mode_r <= cmd.sweep_mode;
      sw_cnt_r  <= '0;
    end else if (sw_act_r) begin
      sw_cnt_r <= sw_cnt_r + IDXW'(1);
    end
    if (cmd.accept) begin
      func_r <= in_tuser;
      addr_r <= in_addr;
      oob_r  <= in_oob;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_start && (cmd.sweep_mode == SW_SCAN)) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      worst_have_r <= 1'b0;
    end else if (p_vld_r && (sw_mode_r == SW_SCAN)) begin
      if (q_valid && (q_tag == addr_r) && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= p_idx_r;
        hit_rank_r  <= q_rank;
      end
      if (!q_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= p_idx_r;
      end
      if (q_valid && (!worst_have_r || (q_rank > worst_rank_r))) begin
        worst_have_r <= 1'b1;
        worst_idx_r  <= p_idx_r;
        worst_rank_r <= q_rank;
        worst_tag_r  <= q_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_early) begin
      res_status_r  <= stat.is_inv ? ST_INVALIDATED : ST_OOB;
      res_slot_r    <= '0;
      res_ev_r      <= 1'b0;
      res_ev_addr_r <= '0;
    end else if (cmd.decide) begin
      res_ev_r      <= 1'b0;
      res_ev_addr_r <= '0;
      res_slot_r    <= '0;
      inc_all_r     <= 1'b0;
      wr_tag_r      <= 1'b0;
      tgt_r         <= hit_idx_r;
      limit_r       <= hit_rank_r;
      if (hit_found_r) begin
        res_status_r <= ST_HIT;
        res_slot_r   <= hit_idx_r;
      end else if (!is_write) begin
        res_status_r <= ST_READ_MISS;
      end else if (evict_case) begin
        res_status_r  <= ST_INSERTED;
        res_slot_r    <= worst_idx_r;
        res_ev_r      <= 1'b1;
        res_ev_addr_r <= worst_tag_r;
        tgt_r         <= worst_idx_r;
        limit_r       <= worst_rank_r;
        wr_tag_r      <= 1'b1;
      end else begin
        res_status_r <= ST_INSERTED;
        res_slot_r   <= free_idx_r;
        tgt_r        <= free_idx_r;
        inc_all_r    <= 1'b1;
        wr_tag_r     <= 1'b1;
      end
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, res_slot_r};
  assign ev_ext   = {{EV_ADDR_W{1'b0}}, res_ev_addr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tuser <= res_status_r;
      out_tdata <= {{OUT_PAD_W{1'b0}}, ev_ext[EV_ADDR_W-1:0], res_ev_r,
                    slot_ext[SLOT_W-1:0]};
    end
  end

endmodule
